### hdl/acpi_madt_entry_parser_core_assert.svh
// Assertion macros used by the MADT entry parser core.
`ifndef ACPI_MADT_ENTRY_PARSER_CORE_ASSERT_SVH
`define ACPI_MADT_ENTRY_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk and disabled while in reset.
`define AMPE_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled while in reset.
`define AMPE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

### hdl/ampe_pkg.sv
// Shared types and constants of the MADT entry parser.
package ampe_pkg;

    localparam int unsigned HEADER_BYTES = 44;
    localparam int unsigned BUF_DEPTH    = 16;

    localparam logic [1:0] KIND_CPU      = 2'd0;
    localparam logic [1:0] KIND_IOAPIC   = 2'd1;
    localparam logic [1:0] KIND_OVERRIDE = 2'd2;
    localparam logic [1:0] KIND_SUMMARY  = 2'd3;

    localparam logic [7:0] ENT_LAPIC    = 8'd0;
    localparam logic [7:0] ENT_IOAPIC   = 8'd1;
    localparam logic [7:0] ENT_OVERRIDE = 8'd2;
    localparam logic [7:0] ENT_BASE     = 8'd5;
    localparam logic [7:0] ENT_X2APIC   = 8'd9;

    typedef struct packed {
        logic accept;
        logic decode;
        logic summary;
    } ampe_cmd_t;

    typedef struct packed {
        logic out_free;
        logic fin_pend;
    } ampe_sts_t;

endpackage

### hdl/ampe_ctrl.sv
// Controller state machine of the MADT entry parser.
module ampe_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ampe_pkg::ampe_sts_t sts,
    output ampe_pkg::ampe_cmd_t cmd
);
    import ampe_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_DECODE  = 2'd1;
    localparam logic [1:0] ST_SUMMARY = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd.accept  = 1'b0;
        cmd.decode  = 1'b0;
        cmd.summary = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.out_free) begin
                    cmd.decode = 1'b1;
                    state_next = sts.fin_pend ? ST_SUMMARY : ST_IDLE;
                end
            end
            ST_SUMMARY: begin
                if (sts.out_free) begin
                    cmd.summary = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/ampe_dp.sv
// Datapath of the MADT entry parser: header capture, record buffer, decode, output register.
module ampe_dp #(
    parameter int MAX_CPUS      = 16,
    parameter int MAX_IOAPICS   = 8,
    parameter int MAX_OVERRIDES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ampe_pkg::ampe_cmd_t cmd,
    output ampe_pkg::ampe_sts_t sts,
    input  logic [7:0]          s_table_byte,
    input  logic                s_final_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_record_kind,
    output logic [7:0]          m_id_a,
    output logic [7:0]          m_id_b,
    output logic [63:0]         m_word_a,
    output logic [31:0]         m_word_b,
    output logic                m_flag_a,
    output logic                m_flag_b,
    output logic [4:0]          m_cpu_total,
    output logic [4:0]          m_enabled_total,
    output logic [3:0]          m_ioapic_total,
    output logic [4:0]          m_override_total,
    output logic                m_run_end
);
    import ampe_pkg::*;

    localparam int CW = $clog2(MAX_CPUS + 1);
    localparam int IW = $clog2(MAX_IOAPICS + 1);
    localparam int OW = $clog2(MAX_OVERRIDES + 1);
    localparam int IX = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

    logic [7:0]  ids_reg [MAX_CPUS];
    logic [7:0]  ebuf_reg [BUF_DEPTH];

    logic [31:0] off_reg, off_next;
    logic [31:0] tlen_reg, tlen_next;
    logic [63:0] base_reg, base_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  elen_reg, elen_next;
    logic        fail_reg, fail_next;
    logic        trunc_reg, trunc_next;
    logic        fin_reg, fin_next;
    logic        finish_reg, finish_next;
    logic [CW-1:0] cpu_reg, cpu_next;
    logic [CW-1:0] en_reg, en_next;
    logic [IW-1:0] io_reg, io_next;
    logic [OW-1:0] ov_reg, ov_next;

    logic        mv_reg, mv_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  ida_reg, ida_next;
    logic [7:0]  idb_reg, idb_next;
    logic [63:0] wa_reg, wa_next;
    logic [31:0] wb_reg, wb_next;
    logic        fa_reg, fa_next;
    logic        fb_reg, fb_next;
    logic [4:0]  ct_reg, ct_next;
    logic [4:0]  et_reg, et_next;
    logic [3:0]  it_reg, it_next;
    logic [4:0]  ot_reg, ot_next;
    logic        re_reg, re_next;

    logic        in_entry;
    logic        buf_wr;
    logic [32:0] span;
    logic [31:0] w4, w8, w12;
    logic [31:0] aid;
    logic [7:0]  pid;
    logic        cpu_en, cpu_oc, cpu_rec, dup, add_go, load;
    logic [31:0] tmp_cpu, tmp_en, tmp_io, tmp_ov;
    logic [4:0]  shamt;

    assign w4  = {ebuf_reg[7], ebuf_reg[6], ebuf_reg[5], ebuf_reg[4]};
    assign w8  = {ebuf_reg[11], ebuf_reg[10], ebuf_reg[9], ebuf_reg[8]};
    assign w12 = {ebuf_reg[15], ebuf_reg[14], ebuf_reg[13], ebuf_reg[12]};

    // Both processor record layouts are folded into one candidate here.
    always_comb begin
        cpu_rec = 1'b0;
        aid     = {24'd0, ebuf_reg[3]};
        pid     = ebuf_reg[2];
        cpu_en  = ebuf_reg[4][0];
        cpu_oc  = ebuf_reg[4][1];
        if (ebuf_reg[0] == ENT_LAPIC && elen_reg >= 8'd8) begin
            cpu_rec = 1'b1;
        end else if (ebuf_reg[0] == ENT_X2APIC && elen_reg >= 8'd16) begin
            cpu_rec = 1'b1;
            aid     = w4;
            pid     = w12[7:0];
            cpu_en  = w8[0];
            cpu_oc  = w8[1];
        end
    end

    always_comb begin
        dup = 1'b0;
        for (int i = 0; i < MAX_CPUS; i++) begin
            if (32'(i) < 32'(cpu_reg) && ids_reg[i] == aid[7:0]) begin
                dup = 1'b1;
            end
        end
    end

    assign in_entry = (off_reg >= 32'(HEADER_BYTES)) && (off_reg < tlen_reg) && !fail_reg;
    assign buf_wr   = cmd.accept && in_entry && (pos_reg < 8'(BUF_DEPTH));
    assign span     = {1'b0, off_reg} - 33'd1 + {25'd0, s_table_byte};
    assign shamt    = {off_reg[1:0], 3'b000};
    assign add_go   = cmd.decode && finish_reg && cpu_rec && (cpu_en || cpu_oc) && !dup
                      && (32'(cpu_reg) < 32'(MAX_CPUS)) && (aid <= 32'd255);

    always_comb begin
        off_next    = off_reg;
        tlen_next   = tlen_reg;
        base_next   = base_reg;
        pos_next    = pos_reg;
        elen_next   = elen_reg;
        fail_next   = fail_reg;
        trunc_next  = trunc_reg;
        fin_next    = fin_reg;
        finish_next = finish_reg;
        cpu_next    = cpu_reg;
        en_next     = en_reg;
        io_next     = io_reg;
        ov_next     = ov_reg;
        load        = 1'b0;
        kind_next   = kind_reg;
        ida_next    = ida_reg;
        idb_next    = idb_reg;
        wa_next     = wa_reg;
        wb_next     = wb_reg;
        fa_next     = fa_reg;
        fb_next     = fb_reg;
        re_next     = re_reg;

        if (cmd.accept) begin
            fin_next = s_final_byte;
            if (off_reg >= 32'd4 && off_reg <= 32'd7) begin
                tlen_next = tlen_reg | (32'(s_table_byte) << shamt);
                if (off_reg == 32'd7 && tlen_next < 32'(HEADER_BYTES)) begin
                    fail_next = 1'b1;
                end
            end else if (off_reg >= 32'd36 && off_reg <= 32'd39) begin
                if (tlen_reg >= 32'(HEADER_BYTES)) begin
                    base_next = base_reg | (64'(s_table_byte) << shamt);
                end
            end else if (in_entry) begin
                priority if (pos_reg == 8'd0) begin
                    pos_next = 8'd1;
                end else if (pos_reg == 8'd1) begin
                    if (s_table_byte < 8'd2 || span > {1'b0, tlen_reg}) begin
                        fail_next = 1'b1;
                        pos_next  = 8'd0;
                    end else begin
                        elen_next = s_table_byte;
                        pos_next  = 8'd2;
                        if (s_table_byte == 8'd2) begin
                            finish_next = 1'b1;
                            pos_next    = 8'd0;
                        end
                    end
                end else begin
                    pos_next = pos_reg + 8'd1;
                    if (pos_next >= elen_reg) begin
                        finish_next = 1'b1;
                        pos_next    = 8'd0;
                    end
                end
            end
            if (off_reg != 32'hFFFF_FFFF) begin
                off_next = off_reg + 32'd1;
            end
        end

        if (cmd.decode) begin
            finish_next = 1'b0;
            re_next     = !fin_reg;
            if (finish_reg) begin
                if (cpu_rec && (cpu_en || cpu_oc) && !dup) begin
                    if (add_go) begin
                        cpu_next  = cpu_reg + 1'b1;
                        en_next   = en_reg + CW'(cpu_en);
                        load      = 1'b1;
                        kind_next = KIND_CPU;
                        ida_next  = pid;
                        idb_next  = aid[7:0];
                        wa_next   = 64'd0;
                        wb_next   = 32'd0;
                        fa_next   = cpu_en;
                        fb_next   = cpu_oc;
                    end else begin
                        trunc_next = 1'b1;
                    end
                end
                if (ebuf_reg[0] == ENT_IOAPIC && elen_reg >= 8'd12
                    && 32'(io_reg) < 32'(MAX_IOAPICS)) begin
                    io_next   = io_reg + 1'b1;
                    load      = 1'b1;
                    kind_next = KIND_IOAPIC;
                    ida_next  = ebuf_reg[2];
                    idb_next  = 8'd0;
                    wa_next   = {32'd0, w4};
                    wb_next   = w8;
                    fa_next   = 1'b0;
                    fb_next   = 1'b0;
                end
                if (ebuf_reg[0] == ENT_OVERRIDE && elen_reg >= 8'd10
                    && 32'(ov_reg) < 32'(MAX_OVERRIDES)) begin
                    ov_next   = ov_reg + 1'b1;
                    load      = 1'b1;
                    kind_next = KIND_OVERRIDE;
                    ida_next  = ebuf_reg[2];
                    idb_next  = ebuf_reg[3];
                    wa_next   = {32'd0, w4};
                    wb_next   = {16'd0, ebuf_reg[9], ebuf_reg[8]};
                    fa_next   = 1'b0;
                    fb_next   = 1'b0;
                end
                if (ebuf_reg[0] == ENT_BASE && elen_reg >= 8'd12) begin
                    base_next = {w8, w4};
                end
            end
        end

        if (cmd.summary) begin
            load      = 1'b1;
            kind_next = KIND_SUMMARY;
            ida_next  = 8'd0;
            idb_next  = 8'd0;
            wa_next   = base_reg;
            wb_next   = 32'd0;
            fa_next   = !fail_reg && (tlen_reg >= 32'(HEADER_BYTES))
                        && (off_reg >= tlen_reg) && (pos_reg == 8'd0);
            fb_next   = trunc_reg;
            re_next   = 1'b1;
        end

        tmp_cpu = 32'(cpu_next);
        tmp_en  = 32'(en_next);
        tmp_io  = 32'(io_next);
        tmp_ov  = 32'(ov_next);
        ct_next = load ? tmp_cpu[4:0] : ct_reg;
        et_next = load ? tmp_en[4:0]  : et_reg;
        it_next = load ? tmp_io[3:0]  : it_reg;
        ot_next = load ? tmp_ov[4:0]  : ot_reg;

        // The summary transaction returns the parse state and counters to their reset values.
        if (cmd.summary) begin
            off_next    = 32'd0;
            tlen_next   = 32'd0;
            base_next   = 64'd0;
            pos_next    = 8'd0;
            elen_next   = 8'd0;
            fail_next   = 1'b0;
            trunc_next  = 1'b0;
            fin_next    = 1'b0;
            finish_next = 1'b0;
            cpu_next    = '0;
            en_next     = '0;
            io_next     = '0;
            ov_next     = '0;
        end

        if (load) begin
            mv_next = 1'b1;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end else begin
            mv_next = mv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg    <= 32'd0;
            tlen_reg   <= 32'd0;
            base_reg   <= 64'd0;
            pos_reg    <= 8'd0;
            elen_reg   <= 8'd0;
            fail_reg   <= 1'b0;
            trunc_reg  <= 1'b0;
            fin_reg    <= 1'b0;
            finish_reg <= 1'b0;
            cpu_reg    <= '0;
            en_reg     <= '0;
            io_reg     <= '0;
            ov_reg     <= '0;
            mv_reg     <= 1'b0;
        end else begin
            off_reg    <= off_next;
            tlen_reg   <= tlen_next;
            base_reg   <= base_next;
            pos_reg    <= pos_next;
            elen_reg   <= elen_next;
            fail_reg   <= fail_next;
            trunc_reg  <= trunc_next;
            fin_reg    <= fin_next;
            finish_reg <= finish_next;
            cpu_reg    <= cpu_next;
            en_reg     <= en_next;
            io_reg     <= io_next;
            ov_reg     <= ov_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        ida_reg  <= ida_next;
        idb_reg  <= idb_next;
        wa_reg   <= wa_next;
        wb_reg   <= wb_next;
        fa_reg   <= fa_next;
        fb_reg   <= fb_next;
        ct_reg   <= ct_next;
        et_reg   <= et_next;
        it_reg   <= it_next;
        ot_reg   <= ot_next;
        re_reg   <= re_next;
        if (buf_wr) begin
            ebuf_reg[pos_reg[3:0]] <= s_table_byte;
        end
        if (add_go) begin
            ids_reg[cpu_reg[IX-1:0]] <= aid[7:0];
        end
    end

    assign sts.out_free = !mv_reg || m_ready;
    assign sts.fin_pend = fin_reg;

    assign m_valid          = mv_reg;
    assign m_record_kind    = kind_reg;
    assign m_id_a           = ida_reg;
    assign m_id_b           = idb_reg;
    assign m_word_a         = wa_reg;
    assign m_word_b         = wb_reg;
    assign m_flag_a         = fa_reg;
    assign m_flag_b         = fb_reg;
    assign m_cpu_total      = ct_reg;
    assign m_enabled_total  = et_reg;
    assign m_ioapic_total   = it_reg;
    assign m_override_total = ot_reg;
    assign m_run_end        = re_reg;

endmodule

### hdl/acpi_madt_entry_parser_core.sv
// Streaming MADT entry parser: one table byte in, processor, I/O APIC,
// override and summary records out.
//
// The s_ channel carries one table byte per transaction, offset 0 first,
// with s_final_byte set on the last byte of the table. The m_ channel carries
// result records; m_run_end marks the last record caused by one input byte.
// Each byte is captured, then its record is decoded into the output register,
// and a final byte adds a summary step; the parser takes no new byte until it
// has finished with the last one. A record appears on m_ once decode, or the
// summary step, loads the output register.
// The controller captures a byte and decodes it in separate cycles.
// A stalled receiver holds the output register; the parser still takes the
// next byte and then waits in decode until the register frees up.
// Reset (aresetn low, synchronous) clears all counters and the header state;
// the summary transaction also returns the parser to this state.
module acpi_madt_entry_parser_core #(
    parameter int MAX_CPUS      = 16,
    parameter int MAX_IOAPICS   = 8,
    parameter int MAX_OVERRIDES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_table_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_record_kind,
    output logic [7:0]  m_id_a,
    output logic [7:0]  m_id_b,
    output logic [63:0] m_word_a,
    output logic [31:0] m_word_b,
    output logic        m_flag_a,
    output logic        m_flag_b,
    output logic [4:0]  m_cpu_total,
    output logic [4:0]  m_enabled_total,
    output logic [3:0]  m_ioapic_total,
    output logic [4:0]  m_override_total,
    output logic        m_run_end
);
    import ampe_pkg::*;

    `include "acpi_madt_entry_parser_core_assert.svh"

    ampe_cmd_t cmd;
    ampe_sts_t sts;

    ampe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ampe_dp #(
        .MAX_CPUS      (MAX_CPUS),
        .MAX_IOAPICS   (MAX_IOAPICS),
        .MAX_OVERRIDES (MAX_OVERRIDES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_table_byte     (s_table_byte),
        .s_final_byte     (s_final_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_record_kind    (m_record_kind),
        .m_id_a           (m_id_a),
        .m_id_b           (m_id_b),
        .m_word_a         (m_word_a),
        .m_word_b         (m_word_b),
        .m_flag_a         (m_flag_a),
        .m_flag_b         (m_flag_b),
        .m_cpu_total      (m_cpu_total),
        .m_enabled_total  (m_enabled_total),
        .m_ioapic_total   (m_ioapic_total),
        .m_override_total (m_override_total),
        .m_run_end        (m_run_end)
    );

    // A byte is always decoded before the next one can be taken.
    `AMPE_ASSERT_NEXT(a_one_byte_at_a_time, s_valid && s_ready, !s_ready,
        "second byte accepted before decode")
    // The summary is always the last record of its byte.
    `AMPE_ASSERT_SAME(a_summary_ends_run, m_valid && m_record_kind == KIND_SUMMARY,
        m_run_end, "summary record without run end")
    // After a final byte is taken, a summary being handed over must not overlap a new byte.
    `AMPE_ASSERT_NEXT(a_summary_clears, s_valid && s_ready && s_final_byte,
        !m_valid || m_record_kind != KIND_SUMMARY || !m_ready || !s_ready,
        "summary overlapped a new byte")

endmodule

### tb/tb_top.sv
// Testbench for the streaming MADT entry parser: table streams in, checked records out.
`timescale 1ns / 100ps

module tb_top;
    import ampe_pkg::*;

    localparam int MAX_CPUS      = 16;
    localparam int MAX_IOAPICS   = 8;
    localparam int MAX_OVERRIDES = 16;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  id_a;
        logic [7:0]  id_b;
        logic [63:0] word_a;
        logic [31:0] word_b;
        logic        flag_a;
        logic        flag_b;
        logic [4:0]  cpus;
        logic [4:0]  enabled;
        logic [3:0]  ioapics;
        logic [4:0]  overrides;
        logic        run_end;
    } madt_rec_t;

    // Tracks the parser state and the records it still owes.
    class madt_scoreboard;
        madt_rec_t   owed_q[$];
        int          mismatches;
        logic [7:0]  apic_ids[MAX_CPUS];
        logic [7:0]  rec_buf[16];
        int unsigned cpu_cnt, en_cnt, io_cnt, ovr_cnt;
        bit          trunc;
        logic [63:0] lapic_base;
        int unsigned offset, tbl_len, rec_pos, rec_len;
        bit          failed;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            foreach (apic_ids[i]) apic_ids[i] = 8'h00;
            foreach (rec_buf[i]) rec_buf[i] = 8'h00;
            cpu_cnt = 0; en_cnt = 0; io_cnt = 0; ovr_cnt = 0;
            trunc = 0; lapic_base = '0;
            offset = 0; tbl_len = 0; rec_pos = 0; rec_len = 0;
            failed = 0;
        endfunction

        function logic [31:0] le32(int at);
            return {rec_buf[(at + 3) & 15], rec_buf[(at + 2) & 15],
                    rec_buf[(at + 1) & 15], rec_buf[at & 15]};
        endfunction

        function void owe(logic [1:0] kind, logic [7:0] ida, logic [7:0] idb,
                          logic [63:0] wa, logic [31:0] wb, logic fa, logic fb);
            madt_rec_t r;
            r.kind = kind; r.id_a = ida; r.id_b = idb;
            r.word_a = wa; r.word_b = wb; r.flag_a = fa; r.flag_b = fb;
            r.cpus = cpu_cnt[4:0]; r.enabled = en_cnt[4:0];
            r.ioapics = io_cnt[3:0]; r.overrides = ovr_cnt[4:0];
            r.run_end = 1'b0;
            owed_q.push_back(r);
        endfunction

        function void add_cpu(logic [31:0] pid, logic [31:0] aid, logic [31:0] flags);
            if (!flags[0] && !flags[1]) return;
            for (int i = 0; i < cpu_cnt && i < MAX_CPUS; i++)
                if (apic_ids[i] == aid[7:0]) return;
            if (cpu_cnt >= MAX_CPUS || aid > 255) begin
                trunc = 1;
                return;
            end
            apic_ids[cpu_cnt] = aid[7:0];
            cpu_cnt++;
            if (flags[0]) en_cnt++;
            owe(KIND_CPU, pid[7:0], aid[7:0], '0, '0, flags[0], flags[1]);
        endfunction

        function void close_record();
            case (rec_buf[0])
                ENT_LAPIC:
                    if (rec_len >= 8) add_cpu(rec_buf[2], rec_buf[3], le32(4));
                ENT_X2APIC:
                    if (rec_len >= 16) add_cpu(le32(12), le32(4), le32(8));
                ENT_IOAPIC:
                    if (rec_len >= 12 && io_cnt < MAX_IOAPICS) begin
                        io_cnt++;
                        owe(KIND_IOAPIC, rec_buf[2], 8'h00, {32'h0, le32(4)}, le32(8),
                            1'b0, 1'b0);
                    end
                ENT_OVERRIDE:
                    if (rec_len >= 10 && ovr_cnt < MAX_OVERRIDES) begin
                        ovr_cnt++;
                        owe(KIND_OVERRIDE, rec_buf[2], rec_buf[3], {32'h0, le32(4)},
                            {16'h0, rec_buf[9], rec_buf[8]}, 1'b0, 1'b0);
                    end
                ENT_BASE:
                    if (rec_len >= 12) lapic_base = {le32(8), le32(4)};
                default: ;
            endcase
            rec_pos = 0;
        endfunction

        function void note_input(logic [7:0] b, logic fin);
            int unsigned off;
            int          before_cnt;
            bit          ok;
            off = offset;
            before_cnt = owed_q.size();
            if (off >= 4 && off <= 7) begin
                tbl_len |= int'(b) << (8 * (off - 4));
                if (off == 7 && tbl_len < HEADER_BYTES) failed = 1;
            end else if (off >= 36 && off <= 39) begin
                if (tbl_len >= HEADER_BYTES)
                    lapic_base |= 64'(b) << (8 * (off - 36));
            end else if (off >= HEADER_BYTES && off < tbl_len && !failed) begin
                if (rec_pos < 16) rec_buf[rec_pos] = b;
                if (rec_pos == 0) begin
                    rec_pos = 1;
                end else if (rec_pos == 1) begin
                    if (b < 2 || longint'(off) - 1 + b > longint'(tbl_len)) begin
                        failed = 1;
                        rec_pos = 0;
                    end else begin
                        rec_len = b;
                        rec_pos = 2;
                        if (b == 2) close_record();
                    end
                end else begin
                    rec_pos++;
                    if (rec_pos >= rec_len) close_record();
                end
            end
            if (offset != 32'hFFFF_FFFF) offset++;
            if (fin) begin
                ok = !failed && tbl_len >= HEADER_BYTES && offset >= tbl_len && rec_pos == 0;
                owe(KIND_SUMMARY, 8'h00, 8'h00, lapic_base, '0, ok, trunc);
                clear();
            end
            if (owed_q.size() > before_cnt) owed_q[owed_q.size() - 1].run_end = 1'b1;
        endfunction

        function void check_record(madt_rec_t got);
            madt_rec_t want;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected record %p", got);
                return;
            end
            want = owed_q.pop_front();
            if (got.kind !== want.kind || got.id_a !== want.id_a || got.id_b !== want.id_b ||
                got.word_a !== want.word_a || got.word_b !== want.word_b ||
                got.flag_a !== want.flag_a || got.flag_b !== want.flag_b ||
                got.cpus !== want.cpus || got.enabled !== want.enabled ||
                got.ioapics !== want.ioapics || got.overrides !== want.overrides ||
                got.run_end !== want.run_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("record mismatch\n  expected %p\n  actual   %p", want, got);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_table_byte;
    logic        s_final_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_record_kind;
    logic [7:0]  m_id_a;
    logic [7:0]  m_id_b;
    logic [63:0] m_word_a;
    logic [31:0] m_word_b;
    logic        m_flag_a;
    logic        m_flag_b;
    logic [4:0]  m_cpu_total;
    logic [4:0]  m_enabled_total;
    logic [3:0]  m_ioapic_total;
    logic [4:0]  m_override_total;
    logic        m_run_end;

    acpi_madt_entry_parser_core #(
        .MAX_CPUS(MAX_CPUS),
        .MAX_IOAPICS(MAX_IOAPICS),
        .MAX_OVERRIDES(MAX_OVERRIDES)
    ) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_table_byte(s_table_byte), .s_final_byte(s_final_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_record_kind(m_record_kind), .m_id_a(m_id_a), .m_id_b(m_id_b),
        .m_word_a(m_word_a), .m_word_b(m_word_b),
        .m_flag_a(m_flag_a), .m_flag_b(m_flag_b),
        .m_cpu_total(m_cpu_total), .m_enabled_total(m_enabled_total),
        .m_ioapic_total(m_ioapic_total), .m_override_total(m_override_total),
        .m_run_end(m_run_end)
    );

    madt_scoreboard madt_sb = new();
    int     send_idle = 0;
    int     recv_idle = 0;
    bit     recv_hold = 0;
    int     cycles = 0;
    logic [7:0] tbl_q[$];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Result side: check every accepted record, then decide the next ready.
    always @(posedge aclk) begin
        madt_rec_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.kind = m_record_kind; got.id_a = m_id_a; got.id_b = m_id_b;
                got.word_a = m_word_a; got.word_b = m_word_b;
                got.flag_a = m_flag_a; got.flag_b = m_flag_b;
                got.cpus = m_cpu_total; got.enabled = m_enabled_total;
                got.ioapics = m_ioapic_total; got.overrides = m_override_total;
                got.run_end = m_run_end;
                madt_sb.check_record(got);
            end
            m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_byte(logic [7:0] b, logic fin);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_table_byte <= b;
        s_final_byte <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        madt_sb.note_input(b, fin);
    endtask

    task automatic push_le(logic [63:0] v, int n);
        for (int i = 0; i < n; i++) tbl_q.push_back(v[8 * i +: 8]);
    endtask

    task automatic start_table();
        tbl_q.delete();
        for (int i = 0; i < 44; i++) tbl_q.push_back(8'($urandom_range(255)));
    endtask

    // Record with given type, declared length and body bytes 2 to 15; later bytes are random.
    task automatic add_rec(logic [7:0] t, int len, logic [127:0] body);
        tbl_q.push_back(t);
        tbl_q.push_back(len[7:0]);
        for (int i = 2; i < len; i++)
            tbl_q.push_back(i < 16 ? body[8 * i +: 8] : 8'($urandom_range(255)));
    endtask

    function automatic logic [127:0] rand_body();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic add_lapic(logic [7:0] pid, logic [7:0] aid, logic [31:0] flags, int pad);
        logic [127:0] b;
        b = rand_body();
        b[23:16] = pid; b[31:24] = aid; b[63:32] = flags;
        add_rec(ENT_LAPIC, 8 + pad, b);
    endtask

    task automatic add_x2(logic [31:0] aid, logic [31:0] flags, logic [31:0] uid, int pad);
        logic [127:0] b;
        b = rand_body();
        b[63:32] = aid; b[95:64] = flags; b[127:96] = uid;
        add_rec(ENT_X2APIC, 16 + pad, b);
    endtask

    // Sends the table with the given length field; keep bytes cut or extend the stream.
    task automatic send_table(int unsigned len_field, int keep);
        for (int i = 0; i < 4; i++) tbl_q[4 + i] = len_field[8 * i +: 8];
        while (tbl_q.size() > keep && tbl_q.size() > 1) void'(tbl_q.pop_back());
        while (tbl_q.size() < keep) tbl_q.push_back(8'($urandom_range(255)));
        for (int i = 0; i < tbl_q.size(); i++)
            send_byte(tbl_q[i], i == tbl_q.size() - 1);
    endtask

    task automatic send_exact();
        send_table(tbl_q.size(), tbl_q.size());
    endtask

    function automatic logic [31:0] rand_flags();
        return ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(3));
    endfunction

    task automatic rand_table();
        int nrec, pick, mode, pad, sz;
        start_table();
        nrec = ($urandom_range(7) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 10);
        for (int i = 0; i < nrec; i++) begin
            pick = $urandom_range(99);
            pad = ($urandom_range(9) == 0) ? $urandom_range(1, 6) : 0;
            if (pick < 30)
                add_lapic(8'($urandom_range(255)), 8'($urandom_range(0, 23)),
                          rand_flags(), pad);
            else if (pick < 42)
                add_x2(($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 23),
                       rand_flags(), $urandom, pad);
            else if (pick < 57) add_rec(ENT_IOAPIC, 12 + pad, rand_body());
            else if (pick < 72) add_rec(ENT_OVERRIDE, 10 + pad, rand_body());
            else if (pick < 80) add_rec(ENT_BASE, 12 + pad, rand_body());
            else if (pick < 88)
                add_rec(8'($urandom_range(255)), $urandom_range(2, 20), rand_body());
            else if (pick < 96)
                add_rec(8'($urandom_range(0, 9)), $urandom_range(2, 9), rand_body());
            else add_rec(8'($urandom_range(255)), $urandom_range(0, 1), rand_body());
        end
        sz = tbl_q.size();
        mode = $urandom_range(99);
        if (mode < 78) send_exact();
        else if (mode < 84) send_table(sz - $urandom_range(1, 8), sz);
        else if (mode < 90) send_table(sz, sz - $urandom_range(1, 6));
        else if (mode < 95) send_table(sz, sz + $urandom_range(1, 6));
        else send_table($urandom_range(43), $urandom_range(8, 50));
    endtask

    // The sender stops offering bytes until every owed record has come back.
    task automatic drain();
        s_valid <= 1'b0;
        wait (madt_sb.owed_q.size() == 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic rand_phase(int s_idle, int r_idle, int bytes);
        int start;
        send_idle = s_idle;
        recv_idle = r_idle;
        start = cycles;
        while (cycles - start < bytes * 3 && bytes > 0) begin
            rand_table();
            bytes -= tbl_q.size();
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_table_byte = 8'h00;
        s_final_byte = 1'b0;
        m_ready      = 1'b0;
        send_idle    = 22;
        recv_idle    = 57;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: all-ones header bytes and each record kind, then the
        // processor list and the I/O APIC and override limits overflowing.
        start_table();
        foreach (tbl_q[i]) tbl_q[i] = 8'hFF;
        add_lapic(8'hFF, 8'hFF, 32'hFFFF_FFFF, 0);
        add_x2(32'h0000_00FE, 32'h2, 32'hFFFF_FFFF, 0);
        add_x2(32'h0000_0100, 32'h1, 32'h0, 0);
        add_lapic(8'h01, 8'hFF, 32'h1, 0);
        add_lapic(8'h02, 8'h07, 32'h0, 0);
        add_rec(ENT_IOAPIC, 12, {128{1'b1}});
        add_rec(ENT_OVERRIDE, 10, {128{1'b1}});
        add_rec(ENT_BASE, 12, {128{1'b1}});
        add_rec(ENT_IOAPIC, 11, rand_body());
        add_rec(8'h07, 2, rand_body());
        add_rec(ENT_LAPIC, 20, rand_body());
        for (int i = 0; i < 16; i++) add_lapic(8'(i), 8'(i), 32'h1, 0);
        for (int i = 0; i < 8; i++) add_rec(ENT_IOAPIC, 12, rand_body());
        for (int i = 0; i < 16; i++) add_rec(ENT_OVERRIDE, 10, rand_body());
        send_exact();
        // Short header length.
        start_table();
        send_table(20, 44);
        // Bad record length, then a record overrunning the table.
        start_table();
        add_rec(ENT_LAPIC, 1, rand_body());
        add_lapic(8'd1, 8'd2, 32'd1, 0);
        send_exact();
        start_table();
        add_lapic(8'd1, 8'd2, 32'd1, 0);
        send_table(48, 52);
        // Early final, then a lone trailing type byte.
        start_table();
        add_lapic(8'd1, 8'd2, 32'd1, 0);
        send_table(52, 48);
        start_table();
        tbl_q.push_back(ENT_LAPIC);
        send_exact();
        drain();

        rand_phase(22, 57, 60);
        drain();
        // Long receiver stall while the sender keeps offering bytes.
        fork
            begin
                recv_hold = 1;
                repeat (400) @(posedge aclk);
                recv_hold = 0;
            end
        join_none
        rand_phase(57, 22, 60);
        drain();
        rand_phase(0, 0, 60);
        drain();
        repeat (20) @(posedge aclk);

        if (madt_sb.mismatches == 0 && madt_sb.owed_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
